// File: rtl/mactp_pkg.sv
// ----------------------------------------------------------------------------
// mactp_pkg
// Shared types, character codes and the hex digit decoder of the MAC address
// text parser.
// ----------------------------------------------------------------------------
package mactp_pkg;

    localparam int MAC_OCTETS = 6;
    localparam int VALUE_W    = 48;

    localparam logic [3:0] OCTET_COUNT = 4'(MAC_OCTETS);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [1:0] SEP_NONE  = 2'd0;
    localparam logic [1:0] SEP_DASH  = 2'd1;
    localparam logic [1:0] SEP_COLON = 2'd2;

    localparam logic STATUS_VALID   = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef enum logic [5:0] {
        PH_D1        = 6'b000001,
        PH_D1_OR_SEP = 6'b000010,
        PH_D2        = 6'b000100,
        PH_SEP       = 6'b001000,
        PH_END       = 6'b010000,
        PH_ERR       = 6'b100000
    } t_phase;

    typedef struct packed {
        t_phase               phase;
        logic [2:0]           octets;
        logic [1:0]           sep;
        logic [VALUE_W-1:0]   value;
    } t_state;

    typedef struct packed {
        logic                 status;
        logic [VALUE_W-1:0]   mac_value;
        logic [1:0]           sep_kind;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    localparam t_state STATE_RESET = '{
        phase:  PH_D1,
        octets: 3'd0,
        sep:    SEP_NONE,
        value:  '0
    };

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        case (c) inside
            [8'h30:8'h39]: h.nib = 4'(c - 8'h30);
            [8'h61:8'h66]: h.nib = 4'(c - 8'h57);
            [8'h41:8'h46]: h.nib = 4'(c - 8'h37);
            default:       h.ok  = 1'b0;
        endcase
        return h;
    endfunction

endpackage

// File: rtl/mactp_step.sv
// ----------------------------------------------------------------------------
// mactp_step
// Next-state and result logic for one text byte of the parser.
// ----------------------------------------------------------------------------
module mactp_step
    import mactp_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_char,
    output t_state     o_state,
    output logic       o_result_valid,
    output t_result    o_result
);

    t_hex       hex;
    logic       take_first;
    logic [3:0] octets_inc;

    assign hex        = hex_decode(i_char);
    assign octets_inc = {1'b0, i_state.octets} + 4'd1;

    always_comb begin
        o_state        = i_state;
        o_result_valid = 1'b0;
        o_result       = '0;
        take_first     = 1'b0;

        if (i_char == CH_NUL) begin
            // The terminator always yields a result and restarts the parse.
            o_result_valid     = 1'b1;
            o_result.status    = (i_state.phase == PH_END) ? STATUS_VALID : STATUS_INVALID;
            o_result.mac_value = (i_state.phase == PH_END) ? i_state.value : '0;
            o_result.sep_kind  = i_state.sep;
            o_state            = STATE_RESET;
        end else begin
            case (i_state.phase)
                PH_D1_OR_SEP: begin
                    if (i_char == CH_DASH) begin
                        o_state.sep   = SEP_DASH;
                        o_state.phase = PH_D1;
                    end else if (i_char == CH_COLON) begin
                        o_state.sep   = SEP_COLON;
                        o_state.phase = PH_D1;
                    end else begin
                        take_first = 1'b1;
                    end
                end
                PH_D1: begin
                    take_first = 1'b1;
                end
                PH_D2: begin
                    if (hex.ok) begin
                        o_state.value = {i_state.value[VALUE_W-5:0], hex.nib};
                        if (octets_inc >= OCTET_COUNT) begin
                            o_state.phase = PH_END;
                        end else begin
                            o_state.octets = octets_inc[2:0];
                            if (octets_inc == 4'd1) begin
                                o_state.phase = PH_D1_OR_SEP;
                            end else begin
                                o_state.phase = (i_state.sep != SEP_NONE) ? PH_SEP : PH_D1;
                            end
                        end
                    end else begin
                        o_state.phase = PH_ERR;
                    end
                end
                PH_SEP: begin
                    if ((i_state.sep == SEP_DASH && i_char == CH_DASH) ||
                        (i_state.sep == SEP_COLON && i_char == CH_COLON)) begin
                        o_state.phase = PH_D1;
                    end else begin
                        o_state.phase = PH_ERR;
                    end
                end
                default: begin
                    o_state.phase = PH_ERR;
                end
            endcase

            // First digit of an octet, also reached when no separator follows
            // the first octet.
            if (take_first) begin
                if (hex.ok) begin
                    o_state.value = {i_state.value[VALUE_W-5:0], hex.nib};
                    o_state.phase = PH_D2;
                end else begin
                    o_state.phase = PH_ERR;
                end
            end
        end
    end

endmodule

// File: rtl/mactp_out_reg.sv
// ----------------------------------------------------------------------------
// mactp_out_reg
// Result register that holds one beat until the receiver takes it.
// ----------------------------------------------------------------------------
module mactp_out_reg
    import mactp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: rtl/mac_address_text_parser.sv
// ----------------------------------------------------------------------------
// mac_address_text_parser
// Parses a MAC address written as text, one ASCII byte per beat.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one byte of text per beat on i_char_in. The text
// is six octets of two hex digits, either case, with no separators or with
// one kind ('-' or ':') between every octet. A NUL byte ends the string.
// Only the NUL beat produces an output beat: o_status (0 valid, 1 invalid),
// o_mac_value (first octet most significant, zero when invalid) and
// o_sep_kind (0 none, 1 dash, 2 colon). After the NUL the parser is back in
// its start state; after a bad byte it ignores text up to the NUL.
// Timing: a byte is captured in the input register; the combinational parse
// step then updates the state and, for a NUL, loads the result register,
// from which the result beat is offered to the receiver. One byte is taken
// every cycle while no NUL waits in the input register (see Stall).
// Stall: while the result register holds a beat that the receiver stalls,
// ordinary bytes still flow through; only a further NUL waits in the input
// register, and then o_in_stall is raised.
// Reset: a synchronous low i_rst_n empties both registers and restores the
// start state (no octets, no separator, zero value).
// ----------------------------------------------------------------------------
module mac_address_text_parser
    import mactp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_char_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_status,
    output logic [VALUE_W-1:0]  o_mac_value,
    output logic [1:0]          o_sep_kind
);

    // Input register.
    logic       r_in_valid;
    logic       n_in_valid;
    logic [7:0] r_in_char;

    // Parse state.
    t_state     r_state;
    t_state     n_state;

    logic       step_result_valid;
    t_result    step_result;
    t_result    out_result;
    logic       out_free;
    logic       advance;
    logic       accept;

    // A held byte moves on unless it is a NUL and the result slot is taken.
    assign advance    = r_in_valid && ((r_in_char != CH_NUL) || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= STATE_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_char_in;
        end
    end

    mactp_step u_step (
        .i_state        (r_state),
        .i_char         (r_in_char),
        .o_state        (n_state),
        .o_result_valid (step_result_valid),
        .o_result       (step_result)
    );

    mactp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && step_result_valid),
        .i_result (step_result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_status    = out_result.status;
    assign o_mac_value = out_result.mac_value;
    assign o_sep_kind  = out_result.sep_kind;

endmodule
